### rtl/wsbs_pkg.sv
// ----------------------------------------------------------------------------
// wsbs_pkg
// Shared types and constants of the 256-bit sign extend, byte select and
// arithmetic shift right unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wsbs_pkg;

  localparam int unsigned WordWidth  = 256;
  localparam int unsigned LimbWidth  = 64;
  localparam int unsigned IndexWidth = 64;
  localparam int unsigned NumBytes   = WordWidth / 8;

  localparam logic [4:0] LastByte = 5'd31;

  typedef enum logic [1:0] {
    OP_SEXT = 2'd0,
    OP_BYTE = 2'd1,
    OP_SAR  = 2'd2
  } opcode_e;

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [LimbWidth-1:0] limb_t;

endpackage

`default_nettype wire

### rtl/word256_signext_byte_sar_unit_core.sv
// ----------------------------------------------------------------------------
// word256_signext_byte_sar_unit_core
// Three-stage pipelined unit for the SIGNEXTEND, BYTE and SAR operations on
// 256-bit stack-machine words.
// ----------------------------------------------------------------------------
// The input channel takes one word per cycle: an opcode, the index operand
// (its low 64 bits and a flag for nonzero upper bits) and a 256-bit value in
// four 64-bit limbs. A word is taken when in_valid_i is high and in_stall_o
// is low. The output channel returns one 256-bit result per word, in four
// limbs, taken when out_valid_o is high and out_stall_i is low.
// A taken word passes through the stage one, two and three registers, and
// out_valid_o is the stage three valid bit; without a stall the throughput
// is one word per cycle. Stage one decodes the operation and performs the
// sign extension, stage two shifts by whole limbs and stage three shifts by
// the bit remainder and drives the output register.
// When the receiver stalls, the output register holds its word and each
// stage holds only while the stage after it is full and held, so bubbles
// are squeezed out; in_stall_o rises once all three stages are full.
// Reset clears the valid bits of all stages but not the data registers.
// ----------------------------------------------------------------------------
`default_nettype none

module word256_signext_byte_sar_unit_core
  import wsbs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            opcode_i,
  input  wire logic [IndexWidth-1:0] index_low_i,
  input  wire logic                  index_high_nonzero_i,
  input  wire limb_t                 value_w0_i,
  input  wire limb_t                 value_w1_i,
  input  wire limb_t                 value_w2_i,
  input  wire limb_t                 value_w3_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output limb_t                      result_w0_o,
  output limb_t                      result_w1_o,
  output limb_t                      result_w2_o,
  output limb_t                      result_w3_o
);

  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic en1, en2, en3;

  word_t      s1_data_d, s1_data_q;
  logic [7:0] s1_amt_d, s1_amt_q;
  logic       s1_fill_d, s1_fill_q;
  logic       s1_sat_d, s1_sat_q;
  logic       s1_bytem_d, s1_bytem_q;

  word_t      s2_data_d, s2_data_q;
  logic [5:0] s2_fine_d, s2_fine_q;
  logic       s2_fill_q;
  logic       s2_bytem_q;

  word_t      s3_data_d, s3_data_q;

  word_t      value;
  logic       idx_lt256, idx_lt32;
  logic [4:0] k;
  word_t      se_mask;
  logic       se_sign;
  word_t      se_result;
  logic [2*WordWidth-1:0]         ext2;
  logic [WordWidth+LimbWidth-1:0] ext3;
  word_t      shifted;

  assign en3 = !s3_valid_q || !out_stall_i;
  assign en2 = !s2_valid_q || en3;
  assign en1 = !s1_valid_q || en2;
  assign in_stall_o = !en1;

  // Stage one: decode and sign extension.
  assign value     = {value_w3_i, value_w2_i, value_w1_i, value_w0_i};
  assign idx_lt256 = !index_high_nonzero_i && (index_low_i[IndexWidth-1:8] == '0);
  assign idx_lt32  = idx_lt256 && (index_low_i[7:5] == 3'd0);
  assign k         = index_low_i[4:0];
  assign se_sign   = value[{k, 3'b111}];

  always_comb begin
    for (int j = 0; j < NumBytes; j++) begin
      se_mask[8*j +: 8] = {8{5'(j) <= k}};
    end
    if (idx_lt32 && (k != LastByte)) begin
      se_result = (value & se_mask) | ({WordWidth{se_sign}} & ~se_mask);
    end else begin
      se_result = value;
    end
  end

  always_comb begin
    s1_data_d  = '0;
    s1_amt_d   = '0;
    s1_fill_d  = 1'b0;
    s1_sat_d   = 1'b0;
    s1_bytem_d = 1'b0;
    case (opcode_e'(opcode_i))
      OP_SEXT: begin
        s1_data_d = se_result;
      end
      OP_BYTE: begin
        s1_data_d  = value;
        s1_amt_d   = {LastByte - k, 3'b000};
        s1_sat_d   = !idx_lt32;
        s1_bytem_d = 1'b1;
      end
      OP_SAR: begin
        s1_data_d = value;
        s1_amt_d  = index_low_i[7:0];
        s1_fill_d = value[WordWidth-1];
        s1_sat_d  = !idx_lt256;
      end
      default: begin
        s1_sat_d = 1'b1;
      end
    endcase
  end

  // Stage two: shift by whole limbs, or saturate to the fill bit.
  assign ext2 = {{WordWidth{s1_fill_q}}, s1_data_q};

  always_comb begin
    if (s1_sat_q) begin
      s2_data_d = {WordWidth{s1_fill_q}};
      s2_fine_d = '0;
    end else begin
      s2_data_d = ext2[{s1_amt_q[7:6], 6'b000000} +: WordWidth];
      s2_fine_d = s1_amt_q[5:0];
    end
  end

  // Stage three: shift by the remaining bits and keep one byte for BYTE.
  assign ext3    = {{LimbWidth{s2_fill_q}}, s2_data_q};
  assign shifted = ext3[s2_fine_q +: WordWidth];
  assign s3_data_d = s2_bytem_q ? {{(WordWidth-8){1'b0}}, shifted[7:0]} : shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q <= in_valid_i;
      if (en2) s2_valid_q <= s1_valid_q;
      if (en3) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_data_q  <= s1_data_d;
      s1_amt_q   <= s1_amt_d;
      s1_fill_q  <= s1_fill_d;
      s1_sat_q   <= s1_sat_d;
      s1_bytem_q <= s1_bytem_d;
    end
    if (en2) begin
      s2_data_q  <= s2_data_d;
      s2_fine_q  <= s2_fine_d;
      s2_fill_q  <= s1_fill_q;
      s2_bytem_q <= s1_bytem_q;
    end
    if (en3) begin
      s3_data_q <= s3_data_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign result_w0_o = s3_data_q[0*LimbWidth +: LimbWidth];
  assign result_w1_o = s3_data_q[1*LimbWidth +: LimbWidth];
  assign result_w2_o = s3_data_q[2*LimbWidth +: LimbWidth];
  assign result_w3_o = s3_data_q[3*LimbWidth +: LimbWidth];

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline has room");

  a_stage_two_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !out_stall_i) |=> out_valid_o)
    else $error("word in stage two was lost");

  a_byte_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_bytem_q && en3) |=> (s3_data_q[WordWidth-1:8] == '0))
    else $error("byte select left upper bits set");

  a_sat_no_fine_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_sat_q && en2) |=> (s2_fine_q == '0))
    else $error("saturated word carries a bit shift");

endmodule

`default_nettype wire
